// File: hdl/kwm_pkg.sv
// Package for the k-way sorted merge core: status codes, command codes and
// controller-to-datapath command and datapath-to-controller status types. No dependencies.
package kwm_pkg;

	localparam logic [1:0] ST_APPENDED = 2'd0;
	localparam logic [1:0] ST_TAKEN    = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_TAKE   = 1'b1;

	// controller commands to the datapath
	typedef struct packed {
		logic latch;      // capture the command fields
		logic mem_read;   // issue a head read for the scan
		logic scan_step;  // fold the returned head into the running minimum
		logic commit;     // update pointers, write memory, emit result
	} kwm_ctl_t;

	// datapath status to the controller
	typedef struct packed {
		logic scan_last;  // final queue scanned
	} kwm_sts_t;

endpackage

// File: hdl/kwm_ctrl.sv
// Controller state machine for the k-way merge core.
// Depends on kwm_pkg.
module kwm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	output logic              busy,
	output kwm_pkg::kwm_ctl_t ctl,
	input  kwm_pkg::kwm_sts_t sts
);
	import kwm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d = (command == CMD_TAKE) ? S_READ : S_DONE;
				end
			end
			S_READ: begin
				ctl.mem_read = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_DONE;
				else ctl.mem_read = 1'b1;
			end
			S_DONE: begin
				ctl.commit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

// File: hdl/kwm_dp.sv
// Datapath for the k-way merge core: element memory, queue pointers, head scan.
// Depends on kwm_pkg.
module kwm_dp #(
	parameter int LISTS       = 8,
	parameter int LIST_DEPTH  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kwm_pkg::kwm_ctl_t ctl,
	output kwm_pkg::kwm_sts_t sts,
	input  logic              command,
	input  logic [2:0]        list_index,
	input  logic [31:0]       value,
	output logic              done,
	output logic [1:0]        status,
	output logic [31:0]       merged_value,
	output logic [2:0]        source_list
);
	import kwm_pkg::*;

	localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
	localparam int PW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = LW + PW;

	// each queue owns a power-of-two slot range addressed as {queue, pointer}
	logic [VALUE_WIDTH-1:0] mem [LISTS << PW];
	logic [PW-1:0] head_q [LISTS];
	logic [PW-1:0] tail_q [LISTS];
	logic [CW-1:0] cnt_q  [LISTS];

	logic              cmd_q;
	logic [2:0]        idx_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [LW-1:0]     rd_q_q;     // queue being read
	logic [LW-1:0]     sc_q_q;     // queue whose data is returning
	logic              sc_ne_q;
	logic [VALUE_WIDTH-1:0] rdata_q;
	logic              have_q;
	logic [LW-1:0]     best_q;
	logic [VALUE_WIDTH-1:0] best_v_q;

	logic [LW-1:0] idx_l;
	logic          idx_ok;
	logic          full;
	logic          better;
	logic [63:0]   best_ext;

	assign idx_l  = LW'(idx_q);
	assign idx_ok = ({29'd0, idx_q} < 32'(LISTS));
	assign full   = !idx_ok || (cnt_q[idx_l] >= CW'(LIST_DEPTH));
	assign better = !have_q || ($signed(rdata_q) < $signed(best_v_q));
	assign sts.scan_last = (sc_q_q == LW'(LISTS - 1));
	assign best_ext = 64'($signed(best_v_q));

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= command;
			idx_q <= list_index;
			val_q <= VALUE_WIDTH'($signed(value));
		end
		if (ctl.mem_read) rdata_q <= mem[{rd_q_q, head_q[rd_q_q]}];
		if (ctl.commit && cmd_q == CMD_APPEND && !full)
			mem[AW'({idx_l, tail_q[idx_l]})] <= val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				head_q[i] <= '0; tail_q[i] <= '0; cnt_q[i] <= '0;
			end
			rd_q_q <= '0; sc_q_q <= '0; sc_ne_q <= 1'b0; have_q <= 1'b0;
			best_q <= '0; best_v_q <= '0;
			done <= 1'b0; status <= ST_APPENDED;
			merged_value <= '0; source_list <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.latch) begin
				rd_q_q <= '0; have_q <= 1'b0;
			end
			if (ctl.mem_read) begin
				sc_q_q  <= rd_q_q;
				sc_ne_q <= (cnt_q[rd_q_q] != '0);
				rd_q_q  <= rd_q_q + 1'b1;
			end
			if (ctl.scan_step && sc_ne_q && better) begin
				have_q <= 1'b1; best_q <= sc_q_q; best_v_q <= rdata_q;
			end
			if (ctl.commit) begin
				done <= 1'b1;
				merged_value <= '0; source_list <= '0;
				if (cmd_q == CMD_APPEND) begin
					if (full) status <= ST_FULL;
					else begin
						status <= ST_APPENDED;
						tail_q[idx_l] <= (tail_q[idx_l] == PW'(LIST_DEPTH - 1)) ? '0
							: tail_q[idx_l] + 1'b1;
						cnt_q[idx_l] <= cnt_q[idx_l] + 1'b1;
					end
				end else if (!have_q) status <= ST_EMPTY;
				else begin
					status <= ST_TAKEN;
					merged_value <= best_ext[31:0];
					source_list <= 3'(best_q);
					head_q[best_q] <= (head_q[best_q] == PW'(LIST_DEPTH - 1)) ? '0
						: head_q[best_q] + 1'b1;
					cnt_q[best_q] <= cnt_q[best_q] - 1'b1;
				end
			end
		end
	end
endmodule

// File: hdl/k_way_sorted_merge_core.sv
// Top level of the k-way sorted merge core.
// Depends on kwm_pkg, kwm_ctrl, kwm_dp.
//
// Usage: drive command, list_index and value with start high; the command
// transfers at the rising edge where start is high and busy is low.
// Append (command 0) places value at the tail of queue list_index. Take
// (command 1) scans the LISTS queue heads one per cycle through the single
// read port of the element memory, keeping the running minimum (lowest
// index wins ties). One command is in flight at a time; the next command
// can transfer at the edge that accepts the result, so a new command is
// not taken before the last one's result appears.
// Each result appears for exactly one cycle with done high:
//   status 0 appended, 1 taken (merged_value, source_list valid),
//   2 all queues empty, 3 queue full, value dropped.
// The receiver cannot stall; it must capture the result in that cycle.
// Reset empties every queue at once; the element memory needs no clearing,
// since heads read from empty queues are ignored by the scan.
module k_way_sorted_merge_core #(
	parameter int LISTS       = 8,
	parameter int LIST_DEPTH  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [2:0]  list_index,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] merged_value,
	output logic [2:0]  source_list
);
	import kwm_pkg::*;

	kwm_ctl_t ctl;
	kwm_sts_t sts;

	kwm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.busy(busy), .ctl(ctl), .sts(sts)
	);

	kwm_dp #(.LISTS(LISTS), .LIST_DEPTH(LIST_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.command(command), .list_index(list_index), .value(value),
		.done(done), .status(status), .merged_value(merged_value),
		.source_list(source_list)
	);
endmodule

// File: hdl/kwm_checker.sv
// Port-level checker for the k-way merge core, bound to the top level.
// Depends on kwm_pkg and k_way_sorted_merge_core.
module kwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] merged_value,
	input logic [2:0]  source_list
);
	import kwm_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after transfer");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result longer than one cycle");
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_TAKEN) |-> (merged_value == '0 && source_list == '0))
		else $error("fields set without take");
endmodule

bind k_way_sorted_merge_core kwm_checker u_kwm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .merged_value(merged_value), .source_list(source_list)
);

// File: tb/tb_k_way_sorted_merge_core.sv
// Testbench for k_way_sorted_merge_core: directed and random append/take traffic,
// checked against a behavioral model of the eight queues and their minimum head.
// Depends on kwm_pkg and the core RTL.
module tb_k_way_sorted_merge_core;
	import kwm_pkg::*;

	localparam int NQ    = 8;
	localparam int DEPTH = 64;
	localparam int LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [2:0]  list_index;
	logic [31:0] value;
	logic        done;
	logic [1:0]  status;
	logic [31:0] merged_value;
	logic [2:0]  source_list;

	k_way_sorted_merge_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .list_index(list_index), .value(value),
		.done(done), .status(status), .merged_value(merged_value),
		.source_list(source_list)
	);

	typedef struct {
		logic [1:0]  st;
		logic [31:0] val;
		logic [2:0]  src;
	} merge_result_t;

	// model state: one queue of values per list
	logic signed [31:0] queue_vals [NQ][$];
	merge_result_t      pending_results [$];
	logic [1:0]         last_st;    // predicted status of the latest transfer

	int errors;
	int cycles;
	int sent;
	int takes_hit;
	int fulls_hit;
	int empties_hit;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= LIMIT);
		$display("timeout after %0d cycles", cycles);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
	endtask

	// predict the result of one command and advance the model
	function automatic merge_result_t predict_merge(input logic cmd, input logic [2:0] idx,
			input logic [31:0] v);
		merge_result_t r;
		int best;
		best = -1;
		r.st = ST_APPENDED;
		r.val = '0;
		r.src = '0;
		if (cmd == CMD_APPEND) begin
			if (queue_vals[idx].size() >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				queue_vals[idx].push_back(v);
			end
		end else begin
			for (int q = 0; q < NQ; q++) begin
				if (queue_vals[q].size() != 0) begin
					// strict less keeps the lowest index on ties
					if (best < 0 || queue_vals[q][0] < queue_vals[best][0]) best = q;
				end
			end
			if (best < 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.st = ST_TAKEN;
				r.val = queue_vals[best].pop_front();
				r.src = best[2:0];
			end
		end
		return r;
	endfunction

	// result checker: done is a one-cycle strobe
	always @(posedge clk) begin
		merge_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {30'd0, status}, 32'd0);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st)
					report_mismatch("status", 32'(status), 32'(exp_r.st));
				if (merged_value !== exp_r.val)
					report_mismatch("merged_value", merged_value, exp_r.val);
				if (source_list !== exp_r.src)
					report_mismatch("source_list", 32'(source_list), 32'(exp_r.src));
				case (exp_r.st)
					ST_TAKEN: takes_hit++;
					ST_FULL:  fulls_hit++;
					ST_EMPTY: empties_hit++;
					default:  ;
				endcase
			end
		end
	end

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 9);
		if (g < 5) g = 0;
		else if (g < 9) g = $urandom_range(1, 3);
		else g = $urandom_range(5, 25);
		repeat (g) @(posedge clk);
	endtask

	// one transfer: hold start until busy is low at an edge
	task automatic send_command(input logic cmd, input logic [2:0] idx, input logic [31:0] v);
		merge_result_t r;
		start      <= 1'b1;
		command    <= cmd;
		list_index <= idx;
		value      <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = predict_merge(cmd, idx, v);
		pending_results.push_back(r);
		last_st = r.st;
		sent++;
		start <= 1'b0;
		// busy is high for the cycle after a transfer, so this costs no rate
		@(posedge clk);
		if ($urandom_range(0, 3) != 0) idle_gap();
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		send_command(CMD_TAKE, 3'd0, 32'hFFFF_FFFF);    // empty take
		send_command(CMD_APPEND, 3'd7, 32'h7FFF_FFFF);
		send_command(CMD_APPEND, 3'd0, 32'h8000_0000);
		send_command(CMD_APPEND, 3'd3, 32'd5);
		send_command(CMD_APPEND, 3'd5, 32'd5);          // tie with list 3
		send_command(CMD_APPEND, 3'd1, 32'hFFFF_FFFF);
		send_command(CMD_APPEND, 3'd2, 32'h5555_AAAA);
		send_command(CMD_APPEND, 3'd4, 32'hAAAA_5555);
		send_command(CMD_APPEND, 3'd6, 32'd0);
		repeat (9) send_command(CMD_TAKE, 3'($urandom), $urandom);
	endtask

	task automatic test_full_queue();
		for (int i = 0; i < DEPTH + 2; i++) send_command(CMD_APPEND, 3'd6, 32'(i - 10));
		send_command(CMD_APPEND, 3'd6, 32'h8000_0000);
		drain();    // sender waits for every expected result
		for (int i = 0; i < DEPTH + 1; i++) send_command(CMD_TAKE, 3'd0, 32'd0);
	endtask

	// sorted runs on random lists, then merged out; some noise mixed in
	task automatic test_random_merge(input int n_items);
		int base [NQ];
		int done_items;
		logic [2:0] q;
		done_items = 0;
		foreach (base[i]) base[i] = $urandom_range(0, 2000) - 1000;
		while (done_items < n_items) begin
			q = 3'($urandom);
			if ($urandom_range(0, 9) < 5) begin
				if ($urandom_range(0, 19) == 0) begin
					send_command(CMD_APPEND, q, $urandom);
				end else begin
					base[q] += $urandom_range(0, 3);
					send_command(CMD_APPEND, q, 32'(base[q]));
				end
			end else begin
				send_command(CMD_TAKE, q, $urandom);
			end
			done_items++;
		end
		while (1) begin
			send_command(CMD_TAKE, 3'd0, 32'd0);
			if (last_st == ST_EMPTY) break;
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		sent = 0;
		takes_hit = 0;
		fulls_hit = 0;
		empties_hit = 0;
		last_st = ST_APPENDED;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_APPEND;
		list_index = '0;
		value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_queue();
		test_random_merge(400);
		drain();
		$display("sent %0d commands: %0d takes, %0d full drops, %0d empty takes",
			sent, takes_hit, fulls_hit, empties_hit);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
